@@ src/mtts_pkg.sv @@
// ============================================================================
// mtts_pkg: shared types and constants for the multi-timeframe trend slope
// Item and result structs, the command passed from front to back, the back
// end state encoding and the period tables for the timeframe histories.
// ============================================================================
`default_nettype none

package mtts_pkg;

    localparam int TF_COUNT    = 14;
    localparam int TF_W        = 4;
    localparam int PRICE_MAX_W = 32;
    localparam int IDX_MAX_W   = 12;
    localparam int LEN_MAX_W   = 13;
    localparam int SLOPE_W     = 40;
    localparam int FRAC_BITS   = 16;
    localparam int SAT_SHIFT   = 23;
    localparam int QUOT_BITS   = 39;
    localparam int STEP_W      = 6;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [SLOPE_W-1:0] SLOPE_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [SLOPE_W-1:0] SLOPE_MIN = 40'h80_0000_0000;

    localparam int MINUTE_PERIOD [7] = '{1, 2, 5, 10, 15, 20, 30};
    localparam int HOUR_PERIOD   [7] = '{1, 2, 3, 4, 6, 8, 12};

    typedef struct packed {
        logic        operation;
        logic [23:0] ask_price;
        logic [23:0] bid_price;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic [3:0]  timeframe;
        logic [10:0] window_length;
    } in_item_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic                      slope_valid;
        logic [TF_COUNT-1:0]       appended_mask;
    } out_item_t;

    typedef struct packed {
        logic                   is_query;
        logic                   query_ok;
        logic [TF_W-1:0]        tf;
        logic [TF_COUNT-1:0]    mask;
        logic [PRICE_MAX_W-1:0] price;
        logic [IDX_MAX_W-1:0]   start;
        logic [LEN_MAX_W-1:0]   len;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WRITE,
        B_READ,
        B_DIVPREP,
        B_DIV,
        B_FINISH
    } back_state_t;

    // Bit k set when minute is a multiple of the k-th minute period.
    function automatic logic [6:0] minute_hits(input logic [5:0] minute);
        logic [6:0] hits;
        hits = '0;
        for (int k = 0; k < 7; k++) begin
            for (int j = 0; j < 64; j++) begin
                if (j * MINUTE_PERIOD[k] == int'(minute))
                    hits[k] = 1'b1;
            end
        end
        return hits;
    endfunction

    function automatic logic [6:0] hour_hits(input logic [4:0] hour);
        logic [6:0] hits;
        hits = '0;
        for (int k = 0; k < 7; k++) begin
            for (int j = 0; j < 32; j++) begin
                if (j * HOUR_PERIOD[k] == int'(hour))
                    hits[k] = 1'b1;
            end
        end
        return hits;
    endfunction

endpackage

`default_nettype wire

@@ src/mtts_front.sv @@
// ============================================================================
// mtts_front: item intake and classification
// Tracks the time of day, fill counts and ring positions, and turns each
// item into a command: histories to append to, or a checked query window.
// ============================================================================
`default_nettype none

module mtts_front #(
    parameter int HISTORY_DEPTH = 1024,
    parameter int PRICE_BITS    = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire mtts_pkg::in_item_t item,
    input  wire logic               queue_full,
    output logic                    push,
    output mtts_pkg::cmd_t          cmd
);

    localparam int XW = $clog2(HISTORY_DEPTH);
    localparam int LW = XW + 1;
    localparam int SW = XW + 2;

    logic [LW-1:0] fill_reg [mtts_pkg::TF_COUNT];
    logic [LW-1:0] fill_next [mtts_pkg::TF_COUNT];
    logic [XW-1:0] wp_reg [mtts_pkg::TF_COUNT];
    logic [XW-1:0] wp_next [mtts_pkg::TF_COUNT];
    logic [5:0]    prev_min_reg, prev_min_next;
    logic [4:0]    prev_hour_reg, prev_hour_next;

    logic                          accept;
    logic                          is_tick;
    logic [24:0]                   quote_sum;
    logic [PRICE_BITS-1:0]         price;
    logic [6:0]                    min_hits, hour_hits;
    logic [mtts_pkg::TF_COUNT-1:0] mask;
    logic                          tf_ok;
    logic [LW-1:0]                 fill_sel;
    logic [XW-1:0]                 wp_sel;
    logic [mtts_pkg::LEN_MAX_W-1:0] len_ext;
    logic                          query_ok;
    logic [SW-1:0]                 start_raw;
    logic [SW-1:0]                 start_fix;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign push       = accept;
    assign is_tick    = (item.operation == mtts_pkg::OP_TICK);

    always_comb
    begin
        quote_sum = {1'b0, item.ask_price} + {1'b0, item.bid_price};
        price     = PRICE_BITS'(quote_sum[24:1]);
        min_hits  = (item.minute_now != prev_min_reg) ?
                    mtts_pkg::minute_hits(item.minute_now) : 7'd0;
        hour_hits = (item.hour_now != prev_hour_reg) ?
                    mtts_pkg::hour_hits(item.hour_now) : 7'd0;
        mask      = {hour_hits, min_hits};

        tf_ok     = (item.timeframe < 4'(mtts_pkg::TF_COUNT));
        fill_sel  = tf_ok ? fill_reg[item.timeframe] : '0;
        wp_sel    = tf_ok ? wp_reg[item.timeframe] : '0;
        len_ext   = mtts_pkg::LEN_MAX_W'(item.window_length);
        query_ok  = tf_ok && (len_ext >= mtts_pkg::LEN_MAX_W'(2))
                    && (len_ext <= mtts_pkg::LEN_MAX_W'(fill_sel));
        // Oldest sample of the window, wrapped around the ring.
        start_raw = SW'(wp_sel) + SW'(HISTORY_DEPTH) - SW'(item.window_length);
        start_fix = (start_raw >= SW'(HISTORY_DEPTH)) ?
                    start_raw - SW'(HISTORY_DEPTH) : start_raw;

        cmd.is_query = !is_tick;
        cmd.query_ok = query_ok;
        cmd.tf       = item.timeframe;
        cmd.mask     = is_tick ? mask : '0;
        cmd.price    = mtts_pkg::PRICE_MAX_W'(price);
        cmd.start    = mtts_pkg::IDX_MAX_W'(start_fix[XW-1:0]);
        cmd.len      = len_ext;
    end

    always_comb
    begin
        prev_min_next  = prev_min_reg;
        prev_hour_next = prev_hour_reg;
        for (int t = 0; t < mtts_pkg::TF_COUNT; t++) begin
            fill_next[t] = fill_reg[t];
            wp_next[t]   = wp_reg[t];
        end
        if (accept && is_tick) begin
            prev_min_next  = item.minute_now;
            prev_hour_next = item.hour_now;
            for (int t = 0; t < mtts_pkg::TF_COUNT; t++) begin
                if (mask[t]) begin
                    if (fill_reg[t] < LW'(HISTORY_DEPTH))
                        fill_next[t] = fill_reg[t] + LW'(1);
                    wp_next[t] = (wp_reg[t] == XW'(HISTORY_DEPTH - 1)) ?
                                 '0 : wp_reg[t] + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_min_reg  <= '0;
            prev_hour_reg <= '0;
            for (int t = 0; t < mtts_pkg::TF_COUNT; t++) begin
                fill_reg[t] <= '0;
                wp_reg[t]   <= '0;
            end
        end else begin
            prev_min_reg  <= prev_min_next;
            prev_hour_reg <= prev_hour_next;
            for (int t = 0; t < mtts_pkg::TF_COUNT; t++) begin
                fill_reg[t] <= fill_next[t];
                wp_reg[t]   <= wp_next[t];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/mtts_queue.sv @@
// ============================================================================
// mtts_queue: two-entry command queue
// Decouples the intake side from the history and slope engine.
// ============================================================================
`default_nettype none

module mtts_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mtts_pkg::cmd_t push_data,
    input  wire logic           pop,
    output mtts_pkg::cmd_t      pop_data,
    output logic                full,
    output logic                empty
);

    mtts_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ src/mtts_back.sv @@
// ============================================================================
// mtts_back: history store and slope engine
// Appends samples to the ring memory, walks a query window accumulating the
// regression sums, then divides bit-serially into a saturated Q24.16 slope.
// ============================================================================
`default_nettype none

module mtts_back #(
    parameter int HISTORY_DEPTH = 1024,
    parameter int PRICE_BITS    = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_empty,
    input  wire mtts_pkg::cmd_t      cmd,
    output logic                     cmd_pop,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output mtts_pkg::out_item_t      result
);

    localparam int XW     = $clog2(HISTORY_DEPTH);
    localparam int LW     = XW + 1;
    localparam int AW     = mtts_pkg::TF_W + XW;
    localparam int MEM_N  = 16 * (2 ** XW);
    localparam int DW     = PRICE_BITS + 1;
    localparam int PN_W   = XW + 1 + DW;
    localparam int NUM_W  = PN_W + XW + 1;
    localparam int DEN_W  = 3 * XW;
    localparam int CMP_W  = NUM_W + DEN_W + mtts_pkg::SAT_SHIFT;
    localparam int QB     = mtts_pkg::QUOT_BITS;
    localparam int SW     = mtts_pkg::SLOPE_W;

    mtts_pkg::back_state_t state_reg, state_next;

    logic [PRICE_BITS-1:0] mem [MEM_N];
    logic [PRICE_BITS-1:0] mem_q_reg;

    logic                          out_load;
    logic                          out_valid_reg;
    mtts_pkg::out_item_t           out_reg;

    logic [mtts_pkg::TF_COUNT-1:0] mask_reg;
    logic [PRICE_BITS-1:0]         price_reg;
    logic [mtts_pkg::TF_W-1:0]     tf_reg;
    logic [LW-1:0]                 len_reg;
    logic [XW-1:0]                 rd_idx_reg;
    logic [LW-1:0]                 issue_cnt_reg;
    logic [XW-1:0]                 wp_reg [mtts_pkg::TF_COUNT];

    logic                          s1_v_reg, s2_v_reg;
    logic [XW-1:0]                 s1_x_reg;
    logic [PRICE_BITS-1:0]         first_reg;
    logic signed [PN_W-1:0]        prod_n_reg;
    logic [2*XW-1:0]               prod_d_reg;
    logic signed [NUM_W-1:0]       num_acc_reg;
    logic [DEN_W-1:0]              den_acc_reg;

    logic                          neg_reg;
    logic [DEN_W-1:0]              rem_reg;
    logic [QB-1:0]                 nsh_reg;
    logic [QB-1:0]                 q_reg;
    logic [mtts_pkg::STEP_W-1:0]   step_reg;

    logic signed [SW-1:0]          res_slope_reg;
    logic                          res_valid_reg;
    logic [mtts_pkg::TF_COUNT-1:0] res_mask_reg;

    // Lowest pending history of a tick
    logic [mtts_pkg::TF_W-1:0]     wr_tf;
    logic [mtts_pkg::TF_COUNT-1:0] rest_mask;
    logic                          issuing;
    logic                          read_done;
    logic [PRICE_BITS-1:0]         base;
    logic signed [DW-1:0]          diff;
    logic signed [XW:0]            xs;
    logic [2*XW-1:0]               xu;
    logic                          neg;
    logic [NUM_W-1:0]              mag;
    logic                          sat;
    logic [NUM_W+mtts_pkg::SAT_SHIFT-1:0] magx;
    logic [DEN_W:0]                rs;
    logic                          ge;
    logic [QB-1:0]                 q_next;
    logic [SW-1:0]                 q_ext;

    always_comb
    begin
        wr_tf     = '0;
        rest_mask = mask_reg;
        for (int t = mtts_pkg::TF_COUNT - 1; t >= 0; t--) begin
            if (mask_reg[t])
                wr_tf = mtts_pkg::TF_W'(t);
        end
        rest_mask[wr_tf] = 1'b0;

        issuing   = (state_reg == mtts_pkg::B_READ) && (issue_cnt_reg != len_reg);
        read_done = (state_reg == mtts_pkg::B_READ) && !issuing && !s1_v_reg && !s2_v_reg;

        base = (s1_x_reg == '0) ? mem_q_reg : first_reg;
        diff = $signed({1'b0, mem_q_reg}) - $signed({1'b0, base});
        xs   = $signed({1'b0, s1_x_reg});
        xu   = (2*XW)'(s1_x_reg);

        neg  = num_acc_reg < 0;
        mag  = neg ? NUM_W'(-num_acc_reg) : NUM_W'(num_acc_reg);
        sat  = CMP_W'(mag) >= (CMP_W'(den_acc_reg) << mtts_pkg::SAT_SHIFT);
        magx = {mtts_pkg::SAT_SHIFT'(0), mag};

        rs     = {rem_reg, nsh_reg[QB-1]};
        ge     = rs >= {1'b0, den_acc_reg};
        q_next = {q_reg[QB-2:0], ge};
        q_ext  = SW'(q_next);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtts_pkg::B_IDLE:
            begin
                if (!cmd_empty) begin
                    if (cmd.is_query)
                        state_next = cmd.query_ok ? mtts_pkg::B_READ : mtts_pkg::B_FINISH;
                    else
                        state_next = (cmd.mask != '0) ? mtts_pkg::B_WRITE
                                                      : mtts_pkg::B_FINISH;
                end
            end
            mtts_pkg::B_WRITE:
            begin
                if (rest_mask == '0)
                    state_next = mtts_pkg::B_FINISH;
            end
            mtts_pkg::B_READ:
            begin
                if (read_done)
                    state_next = mtts_pkg::B_DIVPREP;
            end
            mtts_pkg::B_DIVPREP:
            begin
                state_next = sat ? mtts_pkg::B_FINISH : mtts_pkg::B_DIV;
            end
            mtts_pkg::B_DIV:
            begin
                if (step_reg == mtts_pkg::STEP_W'(1))
                    state_next = mtts_pkg::B_FINISH;
            end
            mtts_pkg::B_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                    state_next = mtts_pkg::B_IDLE;
            end
            default:
            begin
                state_next = mtts_pkg::B_IDLE;
            end
        endcase
    end

    // Strobes
    always_comb
    begin
        cmd_pop  = (state_reg == mtts_pkg::B_IDLE) && !cmd_empty;
        out_load = (state_reg == mtts_pkg::B_FINISH) && (!out_valid_reg || result_ready);
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= mtts_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            for (int t = 0; t < mtts_pkg::TF_COUNT; t++)
                wp_reg[t] <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            s1_v_reg <= issuing;
            s2_v_reg <= s1_v_reg;
            if (state_reg == mtts_pkg::B_WRITE)
                wp_reg[wr_tf] <= (wp_reg[wr_tf] == XW'(HISTORY_DEPTH - 1)) ?
                                 '0 : wp_reg[wr_tf] + XW'(1);
        end
    end

    // History memory: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == mtts_pkg::B_WRITE)
            mem[{wr_tf, wp_reg[wr_tf]}] <= price_reg;
        mem_q_reg <= mem[AW'({tf_reg, rd_idx_reg})];
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_reg.slope         <= res_slope_reg;
            out_reg.slope_valid   <= res_valid_reg;
            out_reg.appended_mask <= res_mask_reg;
        end

        if (cmd_pop) begin
            mask_reg      <= cmd.mask;
            price_reg     <= cmd.price[PRICE_BITS-1:0];
            tf_reg        <= cmd.tf;
            len_reg       <= cmd.len[LW-1:0];
            rd_idx_reg    <= cmd.start[XW-1:0];
            issue_cnt_reg <= '0;
            num_acc_reg   <= '0;
            den_acc_reg   <= '0;
            res_slope_reg <= '0;
            res_valid_reg <= cmd.is_query && cmd.query_ok;
            res_mask_reg  <= cmd.mask;
        end

        if (state_reg == mtts_pkg::B_WRITE)
            mask_reg <= rest_mask;

        if (issuing) begin
            rd_idx_reg    <= (rd_idx_reg == XW'(HISTORY_DEPTH - 1)) ?
                             '0 : rd_idx_reg + XW'(1);
            issue_cnt_reg <= issue_cnt_reg + LW'(1);
            s1_x_reg      <= issue_cnt_reg[XW-1:0];
        end

        if (s1_v_reg) begin
            if (s1_x_reg == '0)
                first_reg <= mem_q_reg;
            prod_n_reg <= PN_W'(xs * diff);
            prod_d_reg <= xu * xu;
        end

        if (s2_v_reg) begin
            num_acc_reg <= num_acc_reg + NUM_W'(prod_n_reg);
            den_acc_reg <= den_acc_reg + DEN_W'(prod_d_reg);
        end

        if (state_reg == mtts_pkg::B_DIVPREP) begin
            neg_reg  <= neg;
            rem_reg  <= DEN_W'(magx[NUM_W+mtts_pkg::SAT_SHIFT-1:mtts_pkg::SAT_SHIFT]);
            nsh_reg  <= {magx[mtts_pkg::SAT_SHIFT-1:0], mtts_pkg::FRAC_BITS'(0)};
            q_reg    <= '0;
            step_reg <= mtts_pkg::STEP_W'(QB);
            if (sat)
                res_slope_reg <= neg ? mtts_pkg::SLOPE_MIN : mtts_pkg::SLOPE_MAX;
        end

        if (state_reg == mtts_pkg::B_DIV) begin
            rem_reg  <= ge ? DEN_W'(rs - {1'b0, den_acc_reg}) : DEN_W'(rs);
            nsh_reg  <= {nsh_reg[QB-2:0], 1'b0};
            q_reg    <= q_next;
            step_reg <= step_reg - mtts_pkg::STEP_W'(1);
            if (step_reg == mtts_pkg::STEP_W'(1))
                res_slope_reg <= neg_reg ? $signed(~q_ext + SW'(1)) : $signed(q_ext);
        end
    end

endmodule

`default_nettype wire

@@ src/multi_timeframe_trend_slope.sv @@
// ============================================================================
// multi_timeframe_trend_slope: fourteen-history price trend slope engine
// Keeps minute and hour price histories and answers regression slope queries.
// ============================================================================
// Usage:
//   item channel (item_valid/item_ready/item): a tick (operation 0) carries a
//   quote and time of day; on a minute or hour change the floored mid price
//   is appended to every matching history. A query (operation 1) asks for the
//   least-squares slope through the origin over the newest window_length
//   samples of one history.
//   result channel (result_valid/result_ready/result): one transfer per item,
//   in order. Ticks return the appended mask, queries the Q24.16 slope.
//   A tick writes one sample per appended history, up to 14, through the one
//   memory write port. A query reads its window through the single read port,
//   accumulates the regression sums in a pipeline and divides bit-serially.
//   A two-entry command queue lets the intake keep taking items while the
//   engine works, and the result register holds a finished result while the
//   receiver stalls; the engine waits there until the result is taken.
//   Reset clears the time of day, fill counts and ring positions; history
//   memory needs no clearing since only filled entries are ever read.
// ============================================================================
`default_nettype none

module multi_timeframe_trend_slope #(
    parameter int HISTORY_DEPTH = 1024,
    parameter int PRICE_BITS    = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire mtts_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output mtts_pkg::out_item_t      result
);

    // Command path between intake and engine
    mtts_pkg::cmd_t front_cmd;
    mtts_pkg::cmd_t queue_cmd;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    // Classify items and track fill state
    mtts_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PRICE_BITS    (PRICE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (front_cmd)
    );

    // Hold commands so each side can stall on its own
    mtts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .pop_data  (queue_cmd),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Append samples, walk windows, divide
    mtts_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PRICE_BITS    (PRICE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (queue_empty),
        .cmd          (queue_cmd),
        .cmd_pop      (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
